@@ rtl/cdbs_pkg.sv @@
// Shared types, constants and lookup functions for the text-display byte stream.
package cdbs_pkg;

  localparam int GlyphColumns   = 6;
  localparam int PanelWidth     = 128;
  localparam int OledCols       = PanelWidth / GlyphColumns;
  localparam int QueueDepthDflt = 2;

  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 8;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DISPLAY_KIND = 2'd0,
    CFG_BACKLIGHT    = 2'd1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    KIND_LCD_16X2 = 2'd0,
    KIND_LCD_20X4 = 2'd1,
    KIND_OLED     = 2'd2,
    KIND_OLED_ALT = 2'd3
  } kind_e;

  typedef enum logic {
    OP_WRITE_CHAR = 1'b0,
    OP_SET_CURSOR = 1'b1
  } op_e;

  localparam logic [7:0] LcdCmdSetAddr = 8'h80;
  localparam logic [7:0] LcdEnable     = 8'h04;
  localparam logic [7:0] LcdBacklight  = 8'h08;
  localparam logic [7:0] LcdRegSel     = 8'h01;
  localparam logic [7:0] OledCtlCmd    = 8'h00;
  localparam logic [7:0] OledCtlData   = 8'h40;
  localparam logic [7:0] OledPageBase  = 8'hB0;
  localparam logic [3:0] OledColHiCmd  = 4'h1;
  localparam logic [5:0] HoldEnHigh    = 6'd1;
  localparam logic [5:0] HoldEnLow     = 6'd50;
  localparam logic [5:0] HoldNone      = 6'd0;

  typedef struct packed {
    logic       op;
    logic [7:0] char_code;
    logic [3:0] row;
    logic [4:0] col;
  } in_t;

  typedef struct packed {
    logic [7:0] bus_byte;
    logic       end_of_transfer;
    logic [5:0] hold_us;
    logic       last;
  } out_t;

  typedef enum logic [1:0] {
    JOB_LCD      = 2'd0,  // two nibbles, four expander bytes
    JOB_OLED_CUR = 2'd1,  // three command transactions
    JOB_OLED_CHR = 2'd2   // control byte, five glyph columns, blank column
  } job_kind_e;

  typedef struct packed {
    job_kind_e  kind;
    logic [7:0] byte_a;  // LCD byte, OLED page command or character
    logic [7:0] byte_b;  // OLED pixel column
    logic       rs;
    logic       bl;
  } job_t;

  function automatic logic [7:0] lcd_row_offset(logic is_20x4, logic [1:0] row);
    logic [7:0] off;
    case (row)
      2'd0:    off = 8'h00;
      2'd1:    off = 8'h40;
      2'd2:    off = is_20x4 ? 8'h14 : 8'h10;
      2'd3:    off = is_20x4 ? 8'h54 : 8'h50;
      default: off = 8'h00;
    endcase
    return off;
  endfunction

  // 5x7 font, columns left to right packed high to low
  function automatic logic [39:0] glyph(logic [7:0] ch);
    logic [39:0] g;
    case (ch)
      8'h30:   g = 40'h3E_51_49_45_3E;
      8'h31:   g = 40'h00_42_7F_40_00;
      8'h32:   g = 40'h42_61_51_49_46;
      8'h33:   g = 40'h21_41_45_4B_31;
      8'h34:   g = 40'h18_14_12_7F_10;
      8'h35:   g = 40'h27_45_45_45_39;
      8'h36:   g = 40'h3C_4A_49_49_30;
      8'h37:   g = 40'h01_71_09_05_03;
      8'h38:   g = 40'h36_49_49_49_36;
      8'h39:   g = 40'h06_49_49_29_1E;
      8'h41:   g = 40'h7E_09_09_09_7E;
      8'h44:   g = 40'h7F_41_41_22_1C;
      8'h45:   g = 40'h7F_49_49_49_41;
      8'h46:   g = 40'h7F_09_09_09_01;
      8'h4C:   g = 40'h7F_40_40_40_40;
      8'h4D:   g = 40'h7F_02_04_02_7F;
      8'h4E:   g = 40'h7F_04_08_10_7F;
      8'h4F:   g = 40'h3E_41_41_41_3E;
      8'h50:   g = 40'h7F_09_09_09_06;
      8'h51:   g = 40'h3E_41_51_21_5E;
      8'h52:   g = 40'h7F_09_19_29_46;
      8'h53:   g = 40'h46_49_49_49_31;
      8'h54:   g = 40'h01_01_7F_01_01;
      8'h58:   g = 40'h63_14_08_14_63;
      8'h3A:   g = 40'h00_36_36_00_00;
      8'h2E:   g = 40'h00_60_60_00_00;
      8'h2D:   g = 40'h08_08_08_08_08;
      8'h2F:   g = 40'h20_10_08_04_02;
      8'h3D:   g = 40'h14_14_14_14_14;
      8'h20:   g = 40'h00_00_00_00_00;
      default: g = 40'h00_00_5F_00_00;
    endcase
    return g;
  endfunction

  function automatic logic [7:0] glyph_col(logic [7:0] ch, logic [2:0] idx);
    logic [39:0] g;
    logic [7:0]  c;
    g = glyph(ch);
    case (idx)
      3'd0:    c = g[39:32];
      3'd1:    c = g[31:24];
      3'd2:    c = g[23:16];
      3'd3:    c = g[15:8];
      3'd4:    c = g[7:0];
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // One bus byte of a job, idx counts bytes from zero
  function automatic out_t job_byte(job_t job, logic [2:0] idx);
    out_t       o;
    logic [7:0] d;
    o = '0;
    d = '0;
    case (job.kind)
      JOB_LCD: begin
        d = idx[1] ? {job.byte_a[3:0], 4'h0} : {job.byte_a[7:4], 4'h0};
        if (job.rs) d = d | LcdRegSel;
        if (job.bl) d = d | LcdBacklight;
        o.end_of_transfer = 1'b1;
        if (!idx[0]) begin
          o.bus_byte = d | LcdEnable;
          o.hold_us  = HoldEnHigh;
        end else begin
          o.bus_byte = d & ~LcdEnable;
          o.hold_us  = HoldEnLow;
        end
        o.last = (idx == 3'd3);
      end
      JOB_OLED_CUR: begin
        o.hold_us = HoldNone;
        if (!idx[0]) begin
          o.bus_byte        = OledCtlCmd;
          o.end_of_transfer = 1'b0;
        end else begin
          o.end_of_transfer = 1'b1;
          case (idx[2:1])
            2'd0:    o.bus_byte = job.byte_a;
            2'd1:    o.bus_byte = {4'h0, job.byte_b[3:0]};
            default: o.bus_byte = {OledColHiCmd, job.byte_b[7:4]};
          endcase
        end
        o.last = (idx == 3'd5);
      end
      JOB_OLED_CHR: begin
        o.hold_us = HoldNone;
        if (idx == 3'd0) begin
          o.bus_byte = OledCtlData;
        end else if (idx == 3'd6) begin
          o.bus_byte        = 8'h00;
          o.end_of_transfer = 1'b1;
          o.last            = 1'b1;
        end else begin
          o.bus_byte = glyph_col(job.byte_a, idx - 3'd1);
        end
      end
      default: begin
        o.last = 1'b1;
      end
    endcase
    return o;
  endfunction

endpackage

@@ rtl/cdbs_front.sv @@
// Front end: accepts requests, keeps the cursor and turns each request into a job.
module cdbs_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [1:0]     kind_i,
  input  logic           backlight_i,
  input  logic           accept_i,
  input  cdbs_pkg::in_t  req_i,
  output logic           job_valid_o,
  output cdbs_pkg::job_t job_o
);

  logic [2:0] row_q, row_d;
  logic [4:0] col_q, col_d;

  logic       oled;
  logic       is_20x4;
  logic [3:0] row_max;
  logic [4:0] col_lim;
  logic [3:0] row_c;
  logic [4:0] col_c;
  logic [7:0] pix_x;
  logic [7:0] addr;

  assign oled    = kind_i[1];
  assign is_20x4 = (kind_i == cdbs_pkg::KIND_LCD_20X4);
  assign row_max = oled ? 4'd7 : (is_20x4 ? 4'd3 : 4'd1);
  assign col_lim = oled ? 5'(cdbs_pkg::OledCols) : (is_20x4 ? 5'd20 : 5'd16);

  assign row_c = (req_i.row > row_max) ? row_max : req_i.row;
  assign col_c = (req_i.col > col_lim - 5'd1) ? col_lim - 5'd1 : req_i.col;
  assign pix_x = 8'({3'b0, col_c} * cdbs_pkg::GlyphColumns);
  assign addr  = cdbs_pkg::LcdCmdSetAddr
               + cdbs_pkg::lcd_row_offset(is_20x4, row_c[1:0]) + {3'b0, col_c};

  always_comb begin
    row_d       = row_q;
    col_d       = col_q;
    job_valid_o = 1'b0;
    job_o       = '0;
    job_o.bl    = backlight_i;
    if (req_i.op == cdbs_pkg::OP_SET_CURSOR) begin
      job_valid_o = accept_i;
      if (accept_i) begin
        row_d = row_c[2:0];
        col_d = col_c;
      end
      if (oled) begin
        job_o.kind   = cdbs_pkg::JOB_OLED_CUR;
        job_o.byte_a = cdbs_pkg::OledPageBase + {4'h0, row_c};
        job_o.byte_b = pix_x;
      end else begin
        job_o.kind   = cdbs_pkg::JOB_LCD;
        job_o.byte_a = addr;
      end
    end else begin
      // a write past the last column is dropped
      if (col_q < col_lim) begin
        job_valid_o = accept_i;
        if (accept_i) col_d = col_q + 5'd1;
      end
      job_o.byte_a = req_i.char_code;
      if (oled) begin
        job_o.kind = cdbs_pkg::JOB_OLED_CHR;
      end else begin
        job_o.kind = cdbs_pkg::JOB_LCD;
        job_o.rs   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

endmodule

@@ rtl/cdbs_queue.sv @@
// Short job queue between the front end and the byte sequencer.
module cdbs_queue #(
  parameter int Depth = cdbs_pkg::QueueDepthDflt
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  cdbs_pkg::job_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           head_valid_o,
  output cdbs_pkg::job_t head_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  cdbs_pkg::job_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o       = (count_q == CntW'(Depth));
  assign head_valid_o = (count_q != '0);
  assign head_o       = mem_q[rd_ptr_q];

  function automatic logic [PtrW-1:0] next_ptr(logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= next_ptr(wr_ptr_q);
      if (pop_i)  rd_ptr_q <= next_ptr(rd_ptr_q);
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + CntW'(1);
        2'b01:   count_q <= count_q - CntW'(1);
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

@@ rtl/cdbs_back.sv @@
// Back end: walks each job byte by byte into the output register.
module cdbs_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           head_valid_i,
  input  cdbs_pkg::job_t head_i,
  output logic           pop_o,
  output logic           out_valid_o,
  output cdbs_pkg::out_t out_data_o,
  input  logic           out_stall_i
);

  logic           busy_q, busy_d;
  cdbs_pkg::job_t job_q, job_d;
  logic [2:0]     idx_q, idx_d;
  logic           out_valid_q, out_valid_d;
  cdbs_pkg::out_t out_q, out_d;

  cdbs_pkg::job_t cur_job;
  logic [2:0]     cur_idx;
  cdbs_pkg::out_t cur_byte;
  logic           advance;

  // with no job in hand the queue head starts at once, so jobs run without gaps
  assign cur_job  = busy_q ? job_q : head_i;
  assign cur_idx  = busy_q ? idx_q : 3'd0;
  assign cur_byte = cdbs_pkg::job_byte(cur_job, cur_idx);
  assign advance  = !out_valid_q || !out_stall_i;

  always_comb begin
    busy_d      = busy_q;
    job_d       = job_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    pop_o       = 1'b0;
    if (advance) begin
      if (busy_q || head_valid_i) begin
        out_valid_d = 1'b1;
        out_d       = cur_byte;
        job_d       = cur_job;
        idx_d       = cur_idx + 3'd1;
        busy_d      = !cur_byte.last;
        pop_o       = !busy_q;
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ rtl/char_display_byte_stream.sv @@
// Top level: text-display request to I2C byte stream generator.
//
// Requests come in on in_valid_i / in_data_i; a word is taken at a clock edge
// with in_valid_i high and in_stall_o low. Each request writes one character
// or sets the cursor. Bus bytes leave on out_valid_o / out_data_o, one word per
// edge with out_valid_o high and out_stall_i low; last marks a request's final byte.
// LCD requests give 4 bytes, an OLED cursor move 6 and an OLED character 7;
// a character past the last column gives none. The byte sequencer emits one
// byte per cycle while the receiver does not stall, and each request's job
// is written to the queue before its first byte reaches the output register.
// The job queue (QueueDepth entries) lets requests be taken while the
// sequencer works; in_stall_o rises only when it is full. When the receiver
// stalls, the output word holds and the sequencer waits, then the queue fills.
// Configuration: cfg_valid_i / cfg_ready_o with cfg_index_i (0 = display kind,
// 1 = backlight) and cfg_data_i; the user must write it only while the block is idle (not enforced by the block).
// Reset clears the cursor, the queue and the output, selects the 16x2 LCD
// and turns the backlight on.
module char_display_byte_stream #(
  parameter int QueueDepth = cdbs_pkg::QueueDepthDflt
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  cdbs_pkg::in_t                 in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output cdbs_pkg::out_t                out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [cdbs_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [cdbs_pkg::CfgDataW-1:0] cfg_data_i
);

  logic [1:0]     kind_q;
  logic           backlight_q;
  logic           q_full;
  logic           in_accept;
  logic           job_valid;
  cdbs_pkg::job_t job;
  logic           head_valid;
  cdbs_pkg::job_t head;
  logic           pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q      <= cdbs_pkg::KIND_LCD_16X2;
      backlight_q <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        cdbs_pkg::CFG_DISPLAY_KIND: kind_q      <= cfg_data_i[1:0];
        cdbs_pkg::CFG_BACKLIGHT:    backlight_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign in_stall_o = q_full;
  assign in_accept  = in_valid_i && !q_full;

  cdbs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .kind_i      (kind_q),
    .backlight_i (backlight_q),
    .accept_i    (in_accept),
    .req_i       (in_data_i),
    .job_valid_o (job_valid),
    .job_o       (job)
  );

  cdbs_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (job_valid),
    .push_data_i  (job),
    .full_o       (q_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  cdbs_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_data_o   (out_data_o),
    .out_stall_i  (out_stall_i)
  );

endmodule

@@ sim/tb_char_display_byte_stream.sv @@
// Testbench for char_display_byte_stream: random and directed requests checked word by word.
`timescale 1ns / 100ps

module tb_char_display_byte_stream;

  localparam int GLYPH_W         = 6;
  localparam int PANEL_W         = 128;
  localparam int SETTLE_CYCLES   = 30;
  localparam int QUIET_LIMIT     = 2000;
  localparam int SQUEEZE_LEN     = 120;
  localparam int SQUEEZE_BACKLOG = 20;
  localparam int SQUEEZE_SPACING = 100;
  localparam int RAND_PHASES     = 8;
  localparam int PHASE_ITEMS     = 36;

  localparam logic [7:0] LCD_SET_ADDR = 8'h80;
  localparam logic [7:0] LCD_EN       = 8'h04;
  localparam logic [7:0] LCD_BL       = 8'h08;
  localparam logic [7:0] LCD_RS       = 8'h01;
  localparam logic [7:0] OLED_CMD     = 8'h00;
  localparam logic [7:0] OLED_DATA    = 8'h40;
  localparam logic [7:0] OLED_PAGE    = 8'hB0;
  localparam logic [3:0] OLED_COL_HI  = 4'h1;
  localparam logic [5:0] HOLD_EN_HI   = 6'd1;
  localparam logic [5:0] HOLD_EN_LO   = 6'd50;
  localparam logic [5:0] HOLD_NONE    = 6'd0;

  logic           clk       = 1'b0;
  logic           rst_n     = 1'b0;
  logic           in_valid  = 1'b0;
  logic           in_stall;
  cdbs_pkg::in_t  in_data   = '0;
  logic           out_valid;
  logic           out_stall = 1'b1;
  cdbs_pkg::out_t out_data;
  logic           cfg_valid = 1'b0;
  logic           cfg_ready;
  logic [cdbs_pkg::CfgIdxW-1:0]  cfg_index = '0;
  logic [cdbs_pkg::CfgDataW-1:0] cfg_data  = '0;

  // shadow of the block's registers and cursor
  cdbs_pkg::kind_e disp_kind;
  logic            bl_on;
  logic [2:0]      cur_row;
  logic [4:0]      cur_col;

  cdbs_pkg::in_t  req_backlog[$];
  cdbs_pkg::out_t bus_bytes_due[$];
  int   items_sent  = 0;
  int   items_taken = 0;
  int   fails       = 0;
  int   words_seen  = 0;
  int   gap_left    = 0;
  int   hold_left   = 0;
  int   squeeze_at  = 100;
  int   quiet_cycles = 0;
  int   roll;
  bit   calm = 1'b0;

  string glyph_chars = "0123456789ADEFLMNOPQRSTX:.-/= ";

  char_display_byte_stream dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic logic [39:0] font_of(logic [7:0] ch);
    case (ch)
      "0":     return 40'h3E_51_49_45_3E;
      "1":     return 40'h00_42_7F_40_00;
      "2":     return 40'h42_61_51_49_46;
      "3":     return 40'h21_41_45_4B_31;
      "4":     return 40'h18_14_12_7F_10;
      "5":     return 40'h27_45_45_45_39;
      "6":     return 40'h3C_4A_49_49_30;
      "7":     return 40'h01_71_09_05_03;
      "8":     return 40'h36_49_49_49_36;
      "9":     return 40'h06_49_49_29_1E;
      "A":     return 40'h7E_09_09_09_7E;
      "D":     return 40'h7F_41_41_22_1C;
      "E":     return 40'h7F_49_49_49_41;
      "F":     return 40'h7F_09_09_09_01;
      "L":     return 40'h7F_40_40_40_40;
      "M":     return 40'h7F_02_04_02_7F;
      "N":     return 40'h7F_04_08_10_7F;
      "O":     return 40'h3E_41_41_41_3E;
      "P":     return 40'h7F_09_09_09_06;
      "Q":     return 40'h3E_41_51_21_5E;
      "R":     return 40'h7F_09_19_29_46;
      "S":     return 40'h46_49_49_49_31;
      "T":     return 40'h01_01_7F_01_01;
      "X":     return 40'h63_14_08_14_63;
      ":":     return 40'h00_36_36_00_00;
      ".":     return 40'h00_60_60_00_00;
      "-":     return 40'h08_08_08_08_08;
      "/":     return 40'h20_10_08_04_02;
      "=":     return 40'h14_14_14_14_14;
      " ":     return 40'h00_00_00_00_00;
      default: return 40'h00_00_5F_00_00;  // no glyph: exclamation bar
    endcase
  endfunction

  function automatic void due(logic [7:0] b, logic eot, logic [5:0] hold, logic fin);
    bus_bytes_due.push_back(cdbs_pkg::out_t'{bus_byte: b, end_of_transfer: eot,
                                             hold_us: hold, last: fin});
  endfunction

  // one nibble on the expander: strobe high, then strobe low
  function automatic void lcd_nibble(logic [3:0] nib, logic rs, logic fin);
    logic [7:0] d;
    d = {nib, 4'h0};
    if (rs) d = d | LCD_RS;
    if (bl_on) d = d | LCD_BL;
    due(d | LCD_EN, 1'b1, HOLD_EN_HI, 1'b0);
    due(d & ~LCD_EN, 1'b1, HOLD_EN_LO, fin);
  endfunction

  function automatic void oled_cmd(logic [7:0] cmd, logic fin);
    due(OLED_CMD, 1'b0, HOLD_NONE, 1'b0);
    due(cmd, 1'b1, HOLD_NONE, fin);
  endfunction

  function automatic void predict_bus_bytes(cdbs_pkg::in_t w);
    logic        oled;
    int unsigned rows, cols, r, c, x;
    logic [7:0]  base, addr;
    logic [39:0] g;
    oled = disp_kind[1];
    rows = oled ? 8 : (disp_kind == cdbs_pkg::KIND_LCD_20X4 ? 4 : 2);
    cols = oled ? PANEL_W / GLYPH_W : (disp_kind == cdbs_pkg::KIND_LCD_20X4 ? 20 : 16);
    if (w.op == cdbs_pkg::OP_SET_CURSOR) begin
      r = (32'(w.row) > rows - 1) ? rows - 1 : 32'(w.row);
      c = (32'(w.col) > cols - 1) ? cols - 1 : 32'(w.col);
      cur_row = r[2:0];
      cur_col = c[4:0];
      if (oled) begin
        x = c * GLYPH_W;
        oled_cmd(OLED_PAGE + r[7:0], 1'b0);
        oled_cmd({4'h0, x[3:0]}, 1'b0);
        oled_cmd({OLED_COL_HI, x[7:4]}, 1'b1);
      end else begin
        case (r[1:0])
          2'd0:    base = 8'h00;
          2'd1:    base = 8'h40;
          2'd2:    base = (disp_kind == cdbs_pkg::KIND_LCD_20X4) ? 8'h14 : 8'h10;
          default: base = (disp_kind == cdbs_pkg::KIND_LCD_20X4) ? 8'h54 : 8'h50;
        endcase
        addr = LCD_SET_ADDR + base + c[7:0];
        lcd_nibble(addr[7:4], 1'b0, 1'b0);
        lcd_nibble(addr[3:0], 1'b0, 1'b1);
      end
    end else begin
      if (32'(cur_col) >= cols) return;  // line full, character dropped
      if (oled) begin
        g = font_of(w.char_code);
        due(OLED_DATA, 1'b0, HOLD_NONE, 1'b0);
        for (int i = 0; i < 5; i++) due(g[39 - 8 * i -: 8], 1'b0, HOLD_NONE, 1'b0);
        due(8'h00, 1'b1, HOLD_NONE, 1'b1);
      end else begin
        lcd_nibble(w.char_code[7:4], 1'b1, 1'b0);
        lcd_nibble(w.char_code[3:0], 1'b1, 1'b1);
      end
      cur_col = cur_col + 5'd1;
    end
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // request driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predict_bus_bytes(in_data);
        items_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (req_backlog.size() > 0) begin
          in_data  <= req_backlog.pop_front();
          in_valid <= 1'b1;
          gap_left = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // byte monitor
  always @(posedge clk) begin
    cdbs_pkg::out_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        words_seen++;
        if (bus_bytes_due.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("unexpected word: byte %h eot %b hold %0d last %b",
                     out_data.bus_byte, out_data.end_of_transfer, out_data.hold_us,
                     out_data.last);
        end else begin
          want = bus_bytes_due.pop_front();
          if (out_data.bus_byte !== want.bus_byte ||
              out_data.end_of_transfer !== want.end_of_transfer ||
              out_data.hold_us !== want.hold_us || out_data.last !== want.last) begin
            fails++;
            if (fails <= 10)
              $display("word %0d mismatch: want %h/%b/%0d/%b got %h/%b/%0d/%b",
                       words_seen, want.bus_byte, want.end_of_transfer, want.hold_us,
                       want.last, out_data.bus_byte, out_data.end_of_transfer,
                       out_data.hold_us, out_data.last);
          end
        end
      end
    end
  end

  // receiver stalls
  always @(posedge clk) begin
    if (rst_n) begin
      // long hold-off while requests are still queued, so the job queue fills
      // and the input backs up
      if (items_taken >= squeeze_at && req_backlog.size() >= SQUEEZE_BACKLOG) begin
        hold_left  = SQUEEZE_LEN;
        squeeze_at = items_taken + SQUEEZE_SPACING;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (calm) begin
        out_stall <= 1'b0;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 65) begin
          out_stall <= 1'b0;
        end else begin
          hold_left = (roll < 95) ? $urandom_range(0, 2) : $urandom_range(8, 30);
          out_stall <= 1'b1;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("char_display_byte_stream regression: fail");
        $finish;
      end
    end
  end

  task automatic send_req(cdbs_pkg::op_e op, logic [7:0] ch, logic [3:0] row,
                          logic [4:0] col);
    req_backlog.push_back(cdbs_pkg::in_t'{op: op, char_code: ch, row: row, col: col});
    items_sent++;
  endtask

  task automatic write_reg(cdbs_pkg::cfg_idx_e idx, logic [7:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      cdbs_pkg::CFG_DISPLAY_KIND: disp_kind = cdbs_pkg::kind_e'(val[1:0]);
      cdbs_pkg::CFG_BACKLIGHT:    bl_on = val[0];
      default: ;
    endcase
  endtask

  // wait until every request is taken and every byte is back, then idle a while
  task automatic drain();
    while (items_taken != items_sent || bus_bytes_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic queue_random(int n);
    cdbs_pkg::op_e op;
    logic [7:0]    ch;
    logic [4:0]    col;
    for (int i = 0; i < n; i++) begin
      op = ($urandom_range(0, 99) < 30) ? cdbs_pkg::OP_SET_CURSOR : cdbs_pkg::OP_WRITE_CHAR;
      if ($urandom_range(0, 1))
        ch = glyph_chars[$urandom_range(0, glyph_chars.len() - 1)];
      else
        ch = 8'($urandom_range(0, 255));
      col = ($urandom_range(0, 9) < 7) ? 5'($urandom_range(0, 12))
                                       : 5'($urandom_range(0, 31));
      send_req(op, ch, 4'($urandom_range(0, 15)), col);
    end
  endtask

  initial begin
    logic [5:0] junk;
    disp_kind = cdbs_pkg::KIND_LCD_16X2;
    bl_on     = 1'b1;
    cur_row   = '0;
    cur_col   = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // 16x2, backlight on out of reset
    send_req(cdbs_pkg::OP_SET_CURSOR, 8'hFF, 4'd0, 5'd0);
    send_req(cdbs_pkg::OP_WRITE_CHAR, 8'h00, 4'd15, 5'd31);
    send_req(cdbs_pkg::OP_WRITE_CHAR, 8'hFF, 4'd0, 5'd0);
    send_req(cdbs_pkg::OP_SET_CURSOR, 8'h00, 4'd15, 5'd31);
    send_req(cdbs_pkg::OP_WRITE_CHAR, "A", 4'd0, 5'd0);
    send_req(cdbs_pkg::OP_WRITE_CHAR, "B", 4'd0, 5'd0);   // past the last column
    send_req(cdbs_pkg::OP_SET_CURSOR, 8'h00, 4'd1, 5'd0);
    drain();

    write_reg(cdbs_pkg::CFG_BACKLIGHT, 8'h00);
    write_reg(cdbs_pkg::CFG_DISPLAY_KIND, 8'(cdbs_pkg::KIND_LCD_20X4));
    send_req(cdbs_pkg::OP_SET_CURSOR, 8'h00, 4'd2, 5'd5);
    send_req(cdbs_pkg::OP_SET_CURSOR, 8'h00, 4'd3, 5'd19);
    send_req(cdbs_pkg::OP_SET_CURSOR, 8'h00, 4'd15, 5'd31);
    send_req(cdbs_pkg::OP_WRITE_CHAR, 8'h5A, 4'd0, 5'd0);
    send_req(cdbs_pkg::OP_WRITE_CHAR, "1", 4'd0, 5'd0);
    drain();

    write_reg(cdbs_pkg::CFG_DISPLAY_KIND, 8'(cdbs_pkg::KIND_OLED));
    write_reg(cdbs_pkg::CFG_BACKLIGHT, 8'h01);
    send_req(cdbs_pkg::OP_SET_CURSOR, 8'h00, 4'd15, 5'd31);
    send_req(cdbs_pkg::OP_WRITE_CHAR, "0", 4'd0, 5'd0);
    send_req(cdbs_pkg::OP_WRITE_CHAR, "Q", 4'd0, 5'd0);
    send_req(cdbs_pkg::OP_SET_CURSOR, 8'h00, 4'd0, 5'd0);
    send_req(cdbs_pkg::OP_WRITE_CHAR, " ", 4'd0, 5'd0);
    send_req(cdbs_pkg::OP_WRITE_CHAR, 8'h7F, 4'd0, 5'd0);
    send_req(cdbs_pkg::OP_WRITE_CHAR, 8'hFF, 4'd0, 5'd0);
    send_req(cdbs_pkg::OP_WRITE_CHAR, "X", 4'd0, 5'd0);
    drain();

    // unused kind code acts as the panel
    write_reg(cdbs_pkg::CFG_DISPLAY_KIND, 8'hFF);
    write_reg(cdbs_pkg::CFG_BACKLIGHT, 8'hFE);
    send_req(cdbs_pkg::OP_SET_CURSOR, 8'h00, 4'd3, 5'd10);
    send_req(cdbs_pkg::OP_WRITE_CHAR, "=", 4'd0, 5'd0);
    send_req(cdbs_pkg::OP_SET_CURSOR, 8'h00, 4'd15, 5'd31);
    drain();

    // cursor at column 20 kept across the switch back to 16 columns
    write_reg(cdbs_pkg::CFG_DISPLAY_KIND, 8'(cdbs_pkg::KIND_LCD_16X2));
    write_reg(cdbs_pkg::CFG_BACKLIGHT, 8'h01);
    send_req(cdbs_pkg::OP_WRITE_CHAR, "5", 4'd0, 5'd0);
    send_req(cdbs_pkg::OP_SET_CURSOR, 8'h00, 4'd9, 5'd3);
    send_req(cdbs_pkg::OP_WRITE_CHAR, "5", 4'd0, 5'd0);
    drain();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      junk = 6'($urandom_range(0, 63));
      write_reg(cdbs_pkg::CFG_DISPLAY_KIND, {junk, 2'(ph % 4)});
      junk = 6'($urandom_range(0, 63));
      write_reg(cdbs_pkg::CFG_BACKLIGHT, {junk, 1'b0, 1'(ph / 4)});
      calm = ($urandom_range(0, 3) == 0);
      queue_random(PHASE_ITEMS);
      drain();
    end

    if (fails == 0 && bus_bytes_due.size() == 0)
      $display("char_display_byte_stream regression: pass");
    else
      $display("char_display_byte_stream regression: fail");
    $finish;
  end

endmodule
